// ----- rtl/ptns_pkg.sv -----
package ptns_pkg;

  localparam int POINT_DEPTH = 256;
  localparam int EDGE_DEPTH = 512;
  localparam int PAW = $clog2(POINT_DEPTH);
  localparam int EAW = $clog2(EDGE_DEPTH);
  localparam int PCW = PAW + 1;
  localparam int ECW = EAW + 1;
  localparam int CW = 24;
  localparam int IW = 8;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [IW-1:0] first_index;
    logic [IW-1:0] second_index;
    logic edge_added;
  } out_req_t;

endpackage

// ----- rtl/ptns_ram.sv -----
module ptns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ptns_dist.sv -----
module ptns_dist (
  input  logic                               clk,
  input  logic signed [ptns_pkg::CW-1:0]     qx,
  input  logic signed [ptns_pkg::CW-1:0]     qy,
  input  logic signed [ptns_pkg::CW-1:0]     px,
  input  logic signed [ptns_pkg::CW-1:0]     py,
  output logic [2*ptns_pkg::CW+2:0]          dsq
);

  logic signed [ptns_pkg::CW:0] dx, dy;
  logic [ptns_pkg::CW:0] adx_r, ady_r;
  logic [2*ptns_pkg::CW+1:0] sx_r, sy_r;

  assign dx = {qx[ptns_pkg::CW-1], qx} - {px[ptns_pkg::CW-1], px};
  assign dy = {qy[ptns_pkg::CW-1], qy} - {py[ptns_pkg::CW-1], py};

  always_ff @(posedge clk) begin
    adx_r <= dx[ptns_pkg::CW] ? -dx : dx;
    ady_r <= dy[ptns_pkg::CW] ? -dy : dy;
    sx_r <= adx_r * adx_r;
    sy_r <= ady_r * ady_r;
  end

  assign dsq = {1'b0, sx_r} + {1'b0, sy_r};

endmodule

// ----- rtl/point_table_nearest_search_top.sv -----
// An add scans the point table, then the edge table when both points are already
// stored, then writes unless a table is full; a query scans the point table; clear,
// unused codes and a query on an empty table go straight to the result.
// One request is in work at a time; the next is taken once the result has left.
// Synchronous active-low reset empties both tables by zeroing the counts.
module point_table_nearest_search_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptns_pkg::in_req_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptns_pkg::out_req_t   out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PSCAN = 3'd1;
  localparam logic [2:0] S_ESCAN = 3'd2;
  localparam logic [2:0] S_WR = 3'd3;
  localparam logic [2:0] S_QSCAN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int PAW = ptns_pkg::PAW;
  localparam int EAW = ptns_pkg::EAW;
  localparam int PCW = ptns_pkg::PCW;
  localparam int ECW = ptns_pkg::ECW;
  localparam int DW = 2 * ptns_pkg::CW + 3;

  logic [2:0] state_r;
  ptns_pkg::in_req_t req_r;
  logic [PCW-1:0] pcnt_r;
  logic [ECW-1:0] ecnt_r;
  logic [ECW:0] idx_r;
  logic rv1_r, rv2_r, rv3_r;
  logic [PCW-1:0] ri1_r, ri2_r, ri3_r;
  logic fa_r, fb_r, fe_r;
  logic [PCW-1:0] ia_r, ib_r;
  logic [DW-1:0] best_d_r;
  logic [PCW-1:0] best_r;
  logic best_v_r;
  logic wstep_r;
  logic out_valid_r;
  ptns_pkg::out_req_t out_r;

  logic [ptns_pkg::CW-1:0] px_q, py_q;
  logic [ptns_pkg::IW-1:0] ef_q, et_q;
  logic [DW-1:0] dsq;

  logic p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [ptns_pkg::CW-1:0] px_w, py_w;
  logic e_we;
  logic [EAW-1:0] e_raddr;

  logic new_a, new_b, same, need_edge, full;
  logic [1:0] need;
  logic [PCW-1:0] ib_f;

  ptns_ram #(.WIDTH(ptns_pkg::CW), .DEPTH(ptns_pkg::POINT_DEPTH)) u_px (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(px_w), .raddr(p_raddr), .rdata(px_q));
  ptns_ram #(.WIDTH(ptns_pkg::CW), .DEPTH(ptns_pkg::POINT_DEPTH)) u_py (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(py_w), .raddr(p_raddr), .rdata(py_q));
  ptns_ram #(.WIDTH(ptns_pkg::IW), .DEPTH(ptns_pkg::EDGE_DEPTH)) u_ef (
    .clk(clk), .we(e_we), .waddr(ecnt_r[EAW-1:0]), .wdata(ia_r[ptns_pkg::IW-1:0]),
    .raddr(e_raddr), .rdata(ef_q));
  ptns_ram #(.WIDTH(ptns_pkg::IW), .DEPTH(ptns_pkg::EDGE_DEPTH)) u_et (
    .clk(clk), .we(e_we), .waddr(ecnt_r[EAW-1:0]), .wdata(ib_f[ptns_pkg::IW-1:0]),
    .raddr(e_raddr), .rdata(et_q));

  ptns_dist u_dist (
    .clk(clk), .qx(req_r.ax), .qy(req_r.ay), .px(px_q), .py(py_q), .dsq(dsq));

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign p_raddr = idx_r[PAW-1:0];
  assign e_raddr = idx_r[EAW-1:0];

  assign new_a = !fa_r;
  assign same = (req_r.ax == req_r.bx) && (req_r.ay == req_r.by);
  assign new_b = !fb_r && !same;
  assign need = {1'b0, new_a} + {1'b0, new_b};
  assign ib_f = new_b ? (pcnt_r + PCW'(new_a)) : (new_a && same ? pcnt_r : ib_r);
  assign need_edge = (need != 2'd0) || !fe_r;
  assign full = ({1'b0, pcnt_r} + (PCW+1)'(need) > (PCW+1)'(ptns_pkg::POINT_DEPTH))
             || (need_edge && ecnt_r >= ECW'(ptns_pkg::EDGE_DEPTH));

  always_comb begin
    p_we = 1'b0;
    p_waddr = pcnt_r[PAW-1:0];
    px_w = req_r.ax;
    py_w = req_r.ay;
    e_we = 1'b0;
    if (state_r == S_WR && !full) begin
      if (!wstep_r) begin
        if (new_a) begin
          p_we = 1'b1;
        end else if (new_b) begin
          p_we = 1'b1;
          px_w = req_r.bx;
          py_w = req_r.by;
        end
      end else begin
        p_we = new_a && new_b;
        p_waddr = pcnt_r[PAW-1:0] + PAW'(1);
        px_w = req_r.bx;
        py_w = req_r.by;
        e_we = need_edge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcnt_r <= '0;
      ecnt_r <= '0;
      out_valid_r <= 1'b0;
      rv1_r <= 1'b0;
      rv2_r <= 1'b0;
      rv3_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      rv1_r <= 1'b0;
      ri1_r <= idx_r[PCW-1:0];
      rv2_r <= rv1_r;
      ri2_r <= ri1_r;
      rv3_r <= rv2_r;
      ri3_r <= ri2_r;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r <= in_data;
            idx_r <= '0;
            fa_r <= 1'b0;
            fb_r <= 1'b0;
            fe_r <= 1'b0;
            ia_r <= pcnt_r;
            ib_r <= pcnt_r;
            best_v_r <= 1'b0;
            best_r <= '0;
            wstep_r <= 1'b0;
            out_r <= '0;
            unique case (in_data.operation)
              ptns_pkg::OP_ADD: state_r <= S_PSCAN;
              ptns_pkg::OP_QUERY: begin
                if (pcnt_r == '0) begin
                  out_r.status <= ptns_pkg::ST_EMPTY;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_QSCAN;
                end
              end
              ptns_pkg::OP_CLEAR: begin
                pcnt_r <= '0;
                ecnt_r <= '0;
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_PSCAN: begin
          if ((ECW+1)'(pcnt_r) > idx_r) begin
            rv1_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
          end
          if (rv1_r) begin
            if (!fa_r && px_q == req_r.ax && py_q == req_r.ay) begin
              fa_r <= 1'b1;
              ia_r <= ri1_r;
            end
            if (!fb_r && px_q == req_r.bx && py_q == req_r.by) begin
              fb_r <= 1'b1;
              ib_r <= ri1_r;
            end
          end
          if (!rv1_r && (ECW+1)'(pcnt_r) <= idx_r) begin
            idx_r <= '0;
            state_r <= S_ESCAN;
          end
        end
        S_ESCAN: begin
          if ((ECW+1)'(ecnt_r) > idx_r && fa_r && fb_r) begin
            rv1_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
          end
          if (rv1_r && ef_q == ia_r[ptns_pkg::IW-1:0] && et_q == ib_r[ptns_pkg::IW-1:0]) begin
            fe_r <= 1'b1;
          end
          if (!rv1_r && ((ECW+1)'(ecnt_r) <= idx_r || !(fa_r && fb_r))) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          wstep_r <= 1'b1;
          if (full) begin
            out_r.status <= ptns_pkg::ST_FULL;
            state_r <= S_DONE;
          end else if (wstep_r) begin
            pcnt_r <= pcnt_r + PCW'(need);
            if (need_edge) begin
              ecnt_r <= ecnt_r + 1'b1;
            end
            out_r.first_index <= ia_r[ptns_pkg::IW-1:0];
            out_r.second_index <= ib_f[ptns_pkg::IW-1:0];
            out_r.edge_added <= need_edge;
            state_r <= S_DONE;
          end
        end
        S_QSCAN: begin
          if ((ECW+1)'(pcnt_r) > idx_r) begin
            rv1_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
          end
          if (rv3_r && (!best_v_r || dsq < best_d_r)) begin
            best_v_r <= 1'b1;
            best_d_r <= dsq;
            best_r <= ri3_r;
          end
          if (!rv1_r && !rv2_r && !rv3_r && (ECW+1)'(pcnt_r) <= idx_r) begin
            out_r.first_index <= best_r[ptns_pkg::IW-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/tb_point_table_nearest_search_top.sv -----
`timescale 1ns / 1ps

module tb_point_table_nearest_search_top;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ptns_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  ptns_pkg::out_req_t out_data;

  point_table_nearest_search_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  logic signed [ptns_pkg::CW-1:0] pt_x [ptns_pkg::POINT_DEPTH];
  logic signed [ptns_pkg::CW-1:0] pt_y [ptns_pkg::POINT_DEPTH];
  int unsigned pt_cnt;
  int unsigned ed_from [ptns_pkg::EDGE_DEPTH];
  int unsigned ed_to [ptns_pkg::EDGE_DEPTH];
  int unsigned ed_cnt;

  ptns_pkg::out_req_t pending_replies[$];
  int errors;
  int gap_max;
  bit hold_long;
  bit bursty_sender;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned lookup_point(logic signed [ptns_pkg::CW-1:0] x,
                                               logic signed [ptns_pkg::CW-1:0] y);
    for (int unsigned i = 0; i < pt_cnt; i++) begin
      if (pt_x[i] == x && pt_y[i] == y) return i;
    end
    return pt_cnt;
  endfunction

  function automatic bit has_edge(int unsigned a, int unsigned b);
    for (int unsigned i = 0; i < ed_cnt; i++) begin
      if (ed_from[i] == a && ed_to[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic ptns_pkg::out_req_t apply_request(ptns_pkg::in_req_t r);
    ptns_pkg::out_req_t o;
    int unsigned ia, ib, need, best;
    bit new_a, new_b, same, need_edge;
    logic [63:0] d, best_d, dx, dy;
    o = '0;
    case (r.operation)
      ptns_pkg::OP_ADD: begin
        ia = lookup_point(r.ax, r.ay);
        ib = lookup_point(r.bx, r.by);
        new_a = (ia == pt_cnt);
        same = (r.ax == r.bx && r.ay == r.by);
        new_b = (ib == pt_cnt) && !same;
        need = int'(new_a) + int'(new_b);
        if (new_a && same) ib = pt_cnt;
        if (new_b) ib = pt_cnt + int'(new_a);
        need_edge = (need != 0) || !has_edge(ia, ib);
        if (pt_cnt + need > ptns_pkg::POINT_DEPTH ||
            (need_edge && ed_cnt >= ptns_pkg::EDGE_DEPTH)) begin
          o.status = ptns_pkg::ST_FULL;
          return o;
        end
        if (new_a) begin
          pt_x[pt_cnt] = r.ax; pt_y[pt_cnt] = r.ay; pt_cnt++;
        end
        if (new_b) begin
          pt_x[pt_cnt] = r.bx; pt_y[pt_cnt] = r.by; pt_cnt++;
        end
        if (need_edge) begin
          ed_from[ed_cnt] = ia; ed_to[ed_cnt] = ib; ed_cnt++;
          o.edge_added = 1'b1;
        end
        o.first_index = ia[ptns_pkg::IW-1:0];
        o.second_index = ib[ptns_pkg::IW-1:0];
      end
      ptns_pkg::OP_QUERY: begin
        if (pt_cnt == 0) begin
          o.status = ptns_pkg::ST_EMPTY;
          return o;
        end
        best = 0;
        best_d = '0;
        for (int unsigned i = 0; i < pt_cnt; i++) begin
          dx = 64'(($signed(64'(r.ax)) - $signed(64'(pt_x[i]))));
          dy = 64'(($signed(64'(r.ay)) - $signed(64'(pt_y[i]))));
          if (dx[63]) dx = -dx;
          if (dy[63]) dy = -dy;
          d = dx * dx + dy * dy;
          if (i == 0 || d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        o.first_index = best[ptns_pkg::IW-1:0];
      end
      ptns_pkg::OP_CLEAR: begin
        pt_cnt = 0;
        ed_cnt = 0;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic send_request(ptns_pkg::in_req_t r);
    int gap;
    gap = bursty_sender && ($urandom_range(0, 3) == 0) ? $urandom_range(1, gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(apply_request(r));
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_replies.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic logic signed [ptns_pkg::CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return ptns_pkg::CW'($urandom_range(0, 15)) - 24'sd8;
      default: return ptns_pkg::CW'($urandom);
    endcase
  endfunction

  function automatic ptns_pkg::in_req_t make_req(logic [1:0] op,
                                                 logic signed [ptns_pkg::CW-1:0] ax,
                                                 logic signed [ptns_pkg::CW-1:0] ay,
                                                 logic signed [ptns_pkg::CW-1:0] bx,
                                                 logic signed [ptns_pkg::CW-1:0] by);
    ptns_pkg::in_req_t r;
    r.operation = op; r.ax = ax; r.ay = ay; r.bx = bx; r.by = by;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply %p", $time, out_data);
        errors++;
      end else begin
        ptns_pkg::out_req_t e;
        e = pending_replies.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.first_index !== e.first_index) begin
          $display("%0t: first_index expected %0d actual %0d", $time, e.first_index,
                   out_data.first_index);
          errors++;
        end
        if (out_data.second_index !== e.second_index) begin
          $display("%0t: second_index expected %0d actual %0d", $time, e.second_index,
                   out_data.second_index);
          errors++;
        end
        if (out_data.edge_added !== e.edge_added) begin
          $display("%0t: edge_added expected %0d actual %0d", $time, e.edge_added,
                   out_data.edge_added);
          errors++;
        end
      end
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  task automatic test_directed();
    send_request(make_req(ptns_pkg::OP_QUERY, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    send_request(make_req(ptns_pkg::OP_ADD, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                          24'sh7FFFFF));
    send_request(make_req(ptns_pkg::OP_ADD, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                          24'sh7FFFFF));
    send_request(make_req(ptns_pkg::OP_ADD, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
                          24'sh800000));
    send_request(make_req(ptns_pkg::OP_ADD, 24'sd5, 24'sd5, 24'sd5, 24'sd5));
    send_request(make_req(ptns_pkg::OP_ADD, 24'sd5, 24'sd5, 24'sd5, 24'sd5));
    send_request(make_req(ptns_pkg::OP_ADD, -24'sd1, -24'sd1, 24'sd5, 24'sd5));
    send_request(make_req(ptns_pkg::OP_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 24'sd0));
    send_request(make_req(ptns_pkg::OP_QUERY, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
                          24'sh7FFFFF));
    send_request(make_req(ptns_pkg::OP_QUERY, 24'sd2, 24'sd2, 24'sd0, 24'sd0));
    send_request(make_req(ptns_pkg::OP_ADD, 24'sd9, 24'sd5, 24'sd1, 24'sd5));
    send_request(make_req(ptns_pkg::OP_QUERY, 24'sd5, 24'sd5, 24'sd0, 24'sd0));
    send_request(make_req(OP_UNUSED, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000));
    send_request(make_req(ptns_pkg::OP_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    send_request(make_req(ptns_pkg::OP_QUERY, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    wait_drained();
  endtask

  task automatic test_random_ops(int n, int coord_span);
    ptns_pkg::in_req_t r;
    for (int i = 0; i < n; i++) begin
      r = make_req(($urandom_range(0, 19) == 0) ? ptns_pkg::OP_CLEAR :
                   ($urandom_range(0, 2) == 0) ? ptns_pkg::OP_QUERY :
                   ($urandom_range(0, 30) == 0) ? OP_UNUSED : ptns_pkg::OP_ADD,
                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
      if (coord_span > 0 && r.operation == ptns_pkg::OP_ADD) begin
        r.ax = ptns_pkg::CW'($urandom_range(0, coord_span));
        r.ay = ptns_pkg::CW'($urandom_range(0, coord_span));
        r.bx = ptns_pkg::CW'($urandom_range(0, coord_span));
        r.by = ptns_pkg::CW'($urandom_range(0, coord_span));
      end
      send_request(r);
    end
    wait_drained();
  endtask

  task automatic test_table_full();
    send_request(make_req(ptns_pkg::OP_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    for (int i = 0; i < 130; i++) begin
      send_request(make_req(ptns_pkg::OP_ADD, ptns_pkg::CW'(2 * i), ptns_pkg::CW'(i),
                            ptns_pkg::CW'(2 * i + 1), -ptns_pkg::CW'(i)));
    end
    for (int i = 0; i < 12; i++) begin
      send_request(make_req(ptns_pkg::OP_QUERY, rand_coord(), rand_coord(), 24'sd0,
                            24'sd0));
    end
    send_request(make_req(ptns_pkg::OP_ADD, 24'sd0, 24'sd0, 24'sd2, 24'sd0));
    for (int i = 0; i < 260; i++) begin
      send_request(make_req(ptns_pkg::OP_ADD,
                            ptns_pkg::CW'($urandom_range(0, 7)),
                            ptns_pkg::CW'($urandom_range(0, 7)),
                            ptns_pkg::CW'($urandom_range(0, 7)),
                            ptns_pkg::CW'($urandom_range(0, 7))));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_long = 1'b1;
    bursty_sender = 1'b0;
    test_random_ops(20, 15);
    bursty_sender = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    gap_max = 20;
    hold_long = 1'b0;
    bursty_sender = 1'b1;
    pt_cnt = 0;
    ed_cnt = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_ops(300, 0);
    test_random_ops(300, 6);
    test_table_full();
    test_random_ops(150, 20);
    wait_drained();
    repeat (600) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tb_point_table_nearest_search_top: done, clean");
    end else begin
      $display("tb_point_table_nearest_search_top: done, errors");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_point_table_nearest_search_top: done, errors");
    $finish;
  end

endmodule
